// File: sv/floppy_block_to_chs_command_sequencer_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the floppy command sequencer
// Shared property templates: overlapped and next-cycle implication.
// ----------------------------------------------------------------------------
`ifndef FLOPPY_BLOCK_TO_CHS_COMMAND_SEQUENCER_DEFINES_SVH
`define FLOPPY_BLOCK_TO_CHS_COMMAND_SEQUENCER_DEFINES_SVH

// Check that cond holds in the same cycle as trig.
`define FBCS_ASSERT_NOW(label, clk, rst_n, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
		else $error(msg);

// Check that cond holds in the cycle after trig.
`define FBCS_ASSERT_NEXT(label, clk, rst_n, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

// File: sv/fbcs_pkg.sv
// ----------------------------------------------------------------------------
// fbcs_pkg
// Types, constants and the microcode program of the floppy command sequencer.
// ----------------------------------------------------------------------------
package fbcs_pkg;

	localparam int BLOCK_W = 16;
	localparam int SPT_W   = 6;
	localparam int HC_W    = 2;
	localparam int BYTE_W  = 8;
	localparam int IDX_W   = 3;
	localparam int DATA_W  = 16;
	localparam int STEP_W  = 5;
	localparam int DCNT_W  = 5;

	localparam logic [DCNT_W-1:0] DIV_STEPS = DCNT_W'(BLOCK_W);

	localparam logic [BYTE_W-1:0] OP_SEEK  = 8'h0F;
	localparam logic [BYTE_W-1:0] OP_RECAL = 8'h07;
	localparam logic [BYTE_W-1:0] SIZE_512 = 8'h02;
	localparam logic [BYTE_W-1:0] FILL_FF  = 8'hFF;

	typedef enum logic [IDX_W-1:0] {
		REG_SPT     = 3'd0,
		REG_HEADS   = 3'd1,
		REG_TOTAL   = 3'd2,
		REG_STRETCH = 3'd3,
		REG_GAP     = 3'd4,
		REG_RD_OP   = 3'd5,
		REG_WR_OP   = 3'd6
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_TRACK = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_ACCEPT,
		ACT_DIV_A,
		ACT_DIV_B,
		ACT_SAVE,
		ACT_EMIT,
		ACT_EMIT_UPD
	} act_t;

	typedef enum logic [3:0] {
		SRC_ZERO,
		SRC_SEEK,
		SRC_RECAL,
		SRC_HEAD4,
		SRC_TRACK,
		SRC_OPCODE,
		SRC_CYL,
		SRC_HEAD,
		SRC_SECTOR,
		SRC_SIZE,
		SRC_SPT,
		SRC_GAP,
		SRC_FF
	} src_t;

	typedef enum logic [2:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_NO_IN,
		COND_DIV_BUSY,
		COND_RANGE,
		COND_TRK_OVF,
		COND_TRK_SAME,
		COND_TRK_ZERO
	} cond_t;

	typedef struct packed {
		act_t              act;
		src_t              src;
		logic              phase;
		logic              last;
		status_t           status;
		cond_t             cond;
		logic [STEP_W-1:0] target;
	} uword_t;

	localparam logic [STEP_W-1:0] STEP_WAIT  = 5'd0;
	localparam logic [STEP_W-1:0] STEP_CHECK = 5'd1;
	localparam logic [STEP_W-1:0] STEP_DIV1  = 5'd2;
	localparam logic [STEP_W-1:0] STEP_DIVB  = 5'd3;
	localparam logic [STEP_W-1:0] STEP_DIV2  = 5'd4;
	localparam logic [STEP_W-1:0] STEP_SAVE  = 5'd5;
	localparam logic [STEP_W-1:0] STEP_OVF   = 5'd6;
	localparam logic [STEP_W-1:0] STEP_SAME  = 5'd7;
	localparam logic [STEP_W-1:0] STEP_ZERO  = 5'd8;
	localparam logic [STEP_W-1:0] STEP_SK0   = 5'd9;
	localparam logic [STEP_W-1:0] STEP_SK1   = 5'd10;
	localparam logic [STEP_W-1:0] STEP_SK2   = 5'd11;
	localparam logic [STEP_W-1:0] STEP_RC0   = 5'd12;
	localparam logic [STEP_W-1:0] STEP_RC1   = 5'd13;
	localparam logic [STEP_W-1:0] STEP_XF0   = 5'd14;
	localparam logic [STEP_W-1:0] STEP_XF1   = 5'd15;
	localparam logic [STEP_W-1:0] STEP_XF2   = 5'd16;
	localparam logic [STEP_W-1:0] STEP_XF3   = 5'd17;
	localparam logic [STEP_W-1:0] STEP_XF4   = 5'd18;
	localparam logic [STEP_W-1:0] STEP_XF5   = 5'd19;
	localparam logic [STEP_W-1:0] STEP_XF6   = 5'd20;
	localparam logic [STEP_W-1:0] STEP_XF7   = 5'd21;
	localparam logic [STEP_W-1:0] STEP_XF8   = 5'd22;
	localparam logic [STEP_W-1:0] STEP_ERR1  = 5'd23;
	localparam logic [STEP_W-1:0] STEP_ERR2  = 5'd24;

	// Microcode program, one control word per step.
	function automatic uword_t ucode_word(input logic [STEP_W-1:0] step);
		uword_t w;
		w = '{act: ACT_NONE, src: SRC_ZERO, phase: 1'b0, last: 1'b0,
			status: ST_OK, cond: COND_NEVER, target: STEP_WAIT};
		case (step)
			STEP_WAIT: begin
				w.act = ACT_ACCEPT; w.cond = COND_NO_IN; w.target = STEP_WAIT;
			end
			STEP_CHECK: begin
				w.act = ACT_DIV_A; w.cond = COND_RANGE; w.target = STEP_ERR1;
			end
			STEP_DIV1: begin
				w.cond = COND_DIV_BUSY; w.target = STEP_DIV1;
			end
			STEP_DIVB: w.act = ACT_DIV_B;
			STEP_DIV2: begin
				w.cond = COND_DIV_BUSY; w.target = STEP_DIV2;
			end
			STEP_SAVE: w.act = ACT_SAVE;
			STEP_OVF: begin
				w.cond = COND_TRK_OVF; w.target = STEP_ERR2;
			end
			STEP_SAME: begin
				w.cond = COND_TRK_SAME; w.target = STEP_XF0;
			end
			STEP_ZERO: begin
				w.cond = COND_TRK_ZERO; w.target = STEP_RC0;
			end
			STEP_SK0: begin
				w.act = ACT_EMIT; w.src = SRC_SEEK;
			end
			STEP_SK1: begin
				w.act = ACT_EMIT; w.src = SRC_HEAD4;
			end
			STEP_SK2: begin
				w.act = ACT_EMIT_UPD; w.src = SRC_TRACK;
				w.cond = COND_ALWAYS; w.target = STEP_XF0;
			end
			STEP_RC0: begin
				w.act = ACT_EMIT; w.src = SRC_RECAL;
			end
			STEP_RC1: begin
				w.act = ACT_EMIT_UPD; w.src = SRC_HEAD4;
			end
			STEP_XF0: begin
				w.act = ACT_EMIT; w.src = SRC_OPCODE; w.phase = 1'b1;
			end
			STEP_XF1: begin
				w.act = ACT_EMIT; w.src = SRC_HEAD4; w.phase = 1'b1;
			end
			STEP_XF2: begin
				w.act = ACT_EMIT; w.src = SRC_CYL; w.phase = 1'b1;
			end
			STEP_XF3: begin
				w.act = ACT_EMIT; w.src = SRC_HEAD; w.phase = 1'b1;
			end
			STEP_XF4: begin
				w.act = ACT_EMIT; w.src = SRC_SECTOR; w.phase = 1'b1;
			end
			STEP_XF5: begin
				w.act = ACT_EMIT; w.src = SRC_SIZE; w.phase = 1'b1;
			end
			STEP_XF6: begin
				w.act = ACT_EMIT; w.src = SRC_SPT; w.phase = 1'b1;
			end
			STEP_XF7: begin
				w.act = ACT_EMIT; w.src = SRC_GAP; w.phase = 1'b1;
			end
			STEP_XF8: begin
				w.act = ACT_EMIT; w.src = SRC_FF; w.phase = 1'b1; w.last = 1'b1;
				w.cond = COND_ALWAYS; w.target = STEP_WAIT;
			end
			STEP_ERR1: begin
				w.act = ACT_EMIT; w.last = 1'b1; w.status = ST_RANGE;
				w.cond = COND_ALWAYS; w.target = STEP_WAIT;
			end
			STEP_ERR2: begin
				w.act = ACT_EMIT; w.last = 1'b1; w.status = ST_TRACK;
				w.cond = COND_ALWAYS; w.target = STEP_WAIT;
			end
			default: begin
				w.cond = COND_ALWAYS; w.target = STEP_WAIT;
			end
		endcase
		return w;
	endfunction

endpackage

// File: sv/floppy_block_to_chs_command_sequencer.sv
// ----------------------------------------------------------------------------
// floppy_block_to_chs_command_sequencer
// Turns a block request into seek/recalibrate and read/write command bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one transaction per sector request,
//   block_number plus func (0 read, 1 write). in_ready is high only while the
//   sequencer waits at its first microcode step, so one request is worked at
//   a time.
//   Output channel (out_valid/out_ready): one transaction per command byte,
//   with phase (0 seek/recalibrate, 1 transfer), last and status. An error
//   gives a single byte 0 with last set and status 1 (range) or 2 (track).
//   Config channel (cfg_valid/cfg_ready): always ready, cfg_index selects
//   the register, cfg_data carries the value; write only while idle.
//   Sequence: a shared 16-step restoring divider runs twice (sectors, then
//   heads). The first byte follows both divisions and the track checks (on a
//   range error, its single byte follows the range check directly), then one
//   byte per cycle while the receiver keeps up. The next request is taken
//   once the sequencer is back at its wait step after the last byte.
//   Reset: geometry returns to 18 sectors, 2 heads, 2880 blocks, and the
//   head position to 255 (unknown). A stalled receiver holds the byte in the
//   output register and freezes the step counter.
// ----------------------------------------------------------------------------
`include "floppy_block_to_chs_command_sequencer_defines.svh"

module floppy_block_to_chs_command_sequencer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [fbcs_pkg::IDX_W-1:0]     cfg_index,
	input  logic [fbcs_pkg::DATA_W-1:0]    cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [fbcs_pkg::BLOCK_W-1:0]   block_number,
	input  logic                           func,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [fbcs_pkg::BYTE_W-1:0]    cmd_byte,
	output logic                           phase,
	output logic                           last,
	output logic [1:0]                     status
);
	import fbcs_pkg::*;

	// Configuration registers
	logic [SPT_W-1:0]   spt_q;
	logic [HC_W-1:0]    heads_q;
	logic [BLOCK_W-1:0] total_q;
	logic               stretch_q;
	logic [BYTE_W-1:0]  gap_q;
	logic [BYTE_W-1:0]  rd_op_q;
	logic [BYTE_W-1:0]  wr_op_q;

	// Sequencer and datapath
	logic [STEP_W-1:0]  step_q;
	logic [STEP_W-1:0]  step_d;
	uword_t             uw;
	logic [BLOCK_W-1:0] block_q;
	logic               func_q;
	logic [BYTE_W-1:0]  pos_q;
	logic [SPT_W-1:0]   sector_q;
	logic [HC_W-1:0]    head_q;
	logic [BLOCK_W-1:0] cyl_q;
	logic [BLOCK_W:0]   seek;

	// Shared restoring divider
	logic [BLOCK_W-1:0] div_quo_q;
	logic [SPT_W-1:0]   div_rem_q;
	logic [SPT_W-1:0]   div_dsr_q;
	logic [DCNT_W-1:0]  div_cnt_q;
	logic               div_busy;
	logic [SPT_W:0]     trial;
	logic               trial_ge;

	// Output register
	logic               out_valid_q;
	logic [BYTE_W-1:0]  byte_q;
	logic               phase_q;
	logic               last_q;
	status_t            status_q;
	logic [BYTE_W-1:0]  byte_d;

	logic range_err;
	logic emit_step;
	logic emit_go;
	logic stall;
	logic cond_hit;

	assign cfg_ready = 1'b1;

	// Configuration writes; indexes past the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spt_q     <= SPT_W'(18);
			heads_q   <= HC_W'(2);
			total_q   <= BLOCK_W'(2880);
			stretch_q <= 1'b0;
			gap_q     <= 8'h1B;
			rd_op_q   <= 8'd230;
			wr_op_q   <= 8'd197;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SPT:     spt_q     <= cfg_data[SPT_W-1:0];
				REG_HEADS:   heads_q   <= cfg_data[HC_W-1:0];
				REG_TOTAL:   total_q   <= cfg_data[BLOCK_W-1:0];
				REG_STRETCH: stretch_q <= cfg_data[0];
				REG_GAP:     gap_q     <= cfg_data[BYTE_W-1:0];
				REG_RD_OP:   rd_op_q   <= cfg_data[BYTE_W-1:0];
				REG_WR_OP:   wr_op_q   <= cfg_data[BYTE_W-1:0];
				default: ;
			endcase
		end
	end

	// Fetch the control word of the current step.
	assign uw = ucode_word(step_q);

	assign in_ready  = (step_q == STEP_WAIT);
	assign range_err = (spt_q == '0) || (heads_q == '0) || (block_q >= total_q);
	assign seek      = stretch_q ? {cyl_q, 1'b0} : {1'b0, cyl_q};

	assign div_busy = (div_cnt_q != '0);
	assign trial    = {div_rem_q, div_quo_q[BLOCK_W-1]};
	assign trial_ge = (trial >= {1'b0, div_dsr_q});

	assign emit_step = (uw.act == ACT_EMIT) || (uw.act == ACT_EMIT_UPD);
	assign stall     = emit_step && out_valid_q && !out_ready;
	assign emit_go   = emit_step && !stall;

	// Evaluate the jump condition of this step.
	always_comb begin
		case (uw.cond)
			COND_NEVER:    cond_hit = 1'b0;
			COND_ALWAYS:   cond_hit = 1'b1;
			COND_NO_IN:    cond_hit = !in_valid;
			COND_DIV_BUSY: cond_hit = div_busy;
			COND_RANGE:    cond_hit = range_err;
			COND_TRK_OVF:  cond_hit = seek[BLOCK_W:BYTE_W] != '0;
			COND_TRK_SAME: cond_hit = seek == {{(BLOCK_W+1-BYTE_W){1'b0}}, pos_q};
			COND_TRK_ZERO: cond_hit = seek == '0;
			default:       cond_hit = 1'b0;
		endcase
	end

	// Hold on a stalled emit, jump when the condition hits, else advance.
	always_comb begin
		if (stall) begin
			step_d = step_q;
		end else if (cond_hit) begin
			step_d = uw.target;
		end else begin
			step_d = step_q + STEP_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_WAIT;
		end else begin
			step_q <= step_d;
		end
	end

	// Request capture and geometry results
	always_ff @(posedge clk) begin
		if (uw.act == ACT_ACCEPT && in_valid) begin
			block_q <= block_number;
			func_q  <= func;
		end
		if (uw.act == ACT_DIV_B) begin
			sector_q <= div_rem_q + SPT_W'(1);
		end
		if (uw.act == ACT_SAVE) begin
			head_q <= div_rem_q[HC_W-1:0];
			cyl_q  <= div_quo_q;
		end
	end

	// Head position: update on the final seek or recalibrate byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 8'hFF;
		end else if (emit_go && uw.act == ACT_EMIT_UPD) begin
			pos_q <= seek[BYTE_W-1:0];
		end
	end

	// Divider: one quotient bit per cycle, dividend shifts out as quotient enters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (uw.act == ACT_DIV_A || uw.act == ACT_DIV_B) begin
			div_cnt_q <= DIV_STEPS;
		end else if (div_busy) begin
			div_cnt_q <= div_cnt_q - DCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (uw.act == ACT_DIV_A) begin
			div_quo_q <= block_q;
			div_dsr_q <= spt_q;
			div_rem_q <= '0;
		end else if (uw.act == ACT_DIV_B) begin
			div_quo_q <= div_quo_q;
			div_dsr_q <= {{(SPT_W-HC_W){1'b0}}, heads_q};
			div_rem_q <= '0;
		end else if (div_busy) begin
			div_quo_q <= {div_quo_q[BLOCK_W-2:0], trial_ge};
			div_rem_q <= trial_ge ? SPT_W'(trial - {1'b0, div_dsr_q}) : trial[SPT_W-1:0];
		end
	end

	// Byte source select
	always_comb begin
		case (uw.src)
			SRC_ZERO:   byte_d = '0;
			SRC_SEEK:   byte_d = OP_SEEK;
			SRC_RECAL:  byte_d = OP_RECAL;
			SRC_HEAD4:  byte_d = {{(BYTE_W-HC_W-2){1'b0}}, head_q, 2'b00};
			SRC_TRACK:  byte_d = seek[BYTE_W-1:0];
			SRC_OPCODE: byte_d = func_q ? wr_op_q : rd_op_q;
			SRC_CYL:    byte_d = cyl_q[BYTE_W-1:0];
			SRC_HEAD:   byte_d = {{(BYTE_W-HC_W){1'b0}}, head_q};
			SRC_SECTOR: byte_d = {{(BYTE_W-SPT_W){1'b0}}, sector_q};
			SRC_SIZE:   byte_d = SIZE_512;
			SRC_SPT:    byte_d = {{(BYTE_W-SPT_W){1'b0}}, spt_q};
			SRC_GAP:    byte_d = gap_q;
			SRC_FF:     byte_d = FILL_FF;
			default:    byte_d = '0;
		endcase
	end

	// Output register: load on emit, drop valid once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			byte_q   <= byte_d;
			phase_q  <= uw.phase;
			last_q   <= uw.last;
			status_q <= uw.status;
		end
	end

	assign out_valid = out_valid_q;
	assign cmd_byte  = byte_q;
	assign phase     = phase_q;
	assign last      = last_q;
	assign status    = status_q;

	`FBCS_ASSERT_NOW(a_err_single, clk, arst_n, out_valid && status != ST_OK, last && cmd_byte == '0, "error result must be a single zero byte")
	`FBCS_ASSERT_NEXT(a_last_to_wait, clk, arst_n, emit_go && uw.last, step_q == STEP_WAIT, "sequencer must return to wait after the last byte")
	`FBCS_ASSERT_NEXT(a_pos_update, clk, arst_n, emit_go && uw.act == ACT_EMIT_UPD, pos_q == $past(seek[BYTE_W-1:0]), "head position must take the seek track")
	`FBCS_ASSERT_NOW(a_no_emit_busy, clk, arst_n, emit_go && uw.status == ST_OK, !div_busy, "command byte emitted while divider is busy")

endmodule
